@@ rtl/qcd_pkg.sv @@
// qcd_pkg: shared types and constants for the quadratic contour decomposer
package qcd_pkg;

	// path command codes
	localparam logic [2:0] CMD_MOVE  = 3'd0;
	localparam logic [2:0] CMD_LINE  = 3'd1;
	localparam logic [2:0] CMD_QUAD  = 3'd2;
	localparam logic [2:0] CMD_CLOSE = 3'd3;
	localparam logic [2:0] CMD_FILL  = 3'd4;

	// positions of the result slots inside one job
	localparam int SLOT_HEAD  = 0;
	localparam int SLOT_CQUAD = 1;
	localparam int SLOT_CLINE = 2;
	localparam int SLOT_CLOSE = 3;
	localparam int SLOT_FILL  = 4;
	localparam int SLOTS      = 5;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one outline point
	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               on_curve;
		logic               contour_end;
		logic               glyph_end;
	} point_t;

	// one path command
	typedef struct packed {
		logic        [2:0]  command;
		logic signed [15:0] ctrl_x;
		logic signed [15:0] ctrl_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic               bad_start;
		logic               last_of_run;
	} result_t;

	// all commands caused by one point, as a slot mask plus operands
	typedef struct packed {
		logic [SLOTS-1:0]   mask;
		logic [2:0]         head_cmd;
		logic signed [15:0] head_cx;
		logic signed [15:0] head_cy;
		logic signed [15:0] head_ex;
		logic signed [15:0] head_ey;
		logic               head_bad;
		logic signed [15:0] pend_x;
		logic signed [15:0] pend_y;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} job_t;

endpackage

@@ rtl/qcd_front.sv @@
// qcd_front: accepts points, tracks contour state and builds one job per point that yields commands
module qcd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pt_valid,
	output logic            pt_ready,
	input  qcd_pkg::point_t pt,
	input  logic            q_full,
	output logic            q_push,
	output qcd_pkg::job_t   q_job
);

	logic               expect_q;
	logic signed [15:0] start_x_q, start_y_q;
	logic signed [15:0] pend_x_q, pend_y_q;
	logic               pend_vld_q;

	logic               expect_n;
	logic signed [15:0] start_x_n, start_y_n;
	logic signed [15:0] pend_x_n, pend_y_n;
	logic               pend_vld_n;
	logic               accept;
	logic signed [16:0] sum_x, sum_y, adj_x, adj_y;
	logic signed [15:0] mid_x, mid_y;

	assign pt_ready = !q_full;
	assign accept   = pt_valid && pt_ready;
	assign q_push   = accept && (q_job.mask != '0);

	// midpoint of held control and new control, truncated toward zero
	always_comb begin
		sum_x = {pend_x_q[15], pend_x_q} + {pt.point_x[15], pt.point_x};
		sum_y = {pend_y_q[15], pend_y_q} + {pt.point_y[15], pt.point_y};
		adj_x = sum_x + {16'd0, sum_x[16]};
		adj_y = sum_y + {16'd0, sum_y[16]};
		mid_x = adj_x[16:1];
		mid_y = adj_y[16:1];
	end

	// classify the point and work out the next state
	always_comb begin
		expect_n   = expect_q;
		start_x_n  = start_x_q;
		start_y_n  = start_y_q;
		pend_x_n   = pend_x_q;
		pend_y_n   = pend_y_q;
		pend_vld_n = pend_vld_q;
		q_job      = '0;

		if (expect_q) begin
			q_job.mask[qcd_pkg::SLOT_HEAD] = 1'b1;
			q_job.head_cmd = qcd_pkg::CMD_MOVE;
			q_job.head_ex  = pt.point_x;
			q_job.head_ey  = pt.point_y;
			q_job.head_bad = !pt.on_curve;
			start_x_n  = pt.point_x;
			start_y_n  = pt.point_y;
			pend_vld_n = 1'b0;
			expect_n   = 1'b0;
		end else if (pt.on_curve) begin
			q_job.mask[qcd_pkg::SLOT_HEAD] = 1'b1;
			q_job.head_cmd = pend_vld_q ? qcd_pkg::CMD_QUAD : qcd_pkg::CMD_LINE;
			q_job.head_cx  = pend_vld_q ? pend_x_q : 16'sd0;
			q_job.head_cy  = pend_vld_q ? pend_y_q : 16'sd0;
			q_job.head_ex  = pt.point_x;
			q_job.head_ey  = pt.point_y;
			pend_vld_n = 1'b0;
		end else begin
			q_job.mask[qcd_pkg::SLOT_HEAD] = pend_vld_q;
			q_job.head_cmd = qcd_pkg::CMD_QUAD;
			q_job.head_cx  = pend_x_q;
			q_job.head_cy  = pend_y_q;
			q_job.head_ex  = mid_x;
			q_job.head_ey  = mid_y;
			pend_x_n   = pt.point_x;
			pend_y_n   = pt.point_y;
			pend_vld_n = 1'b1;
		end

		// contour end, also implied by glyph end
		if (pt.contour_end || pt.glyph_end) begin
			q_job.mask[qcd_pkg::SLOT_CQUAD] = pend_vld_n;
			q_job.mask[qcd_pkg::SLOT_CLINE] = 1'b1;
			q_job.mask[qcd_pkg::SLOT_CLOSE] = 1'b1;
			pend_vld_n = 1'b0;
			expect_n   = 1'b1;
		end
		q_job.mask[qcd_pkg::SLOT_FILL] = pt.glyph_end;

		q_job.pend_x  = pend_x_n;
		q_job.pend_y  = pend_y_n;
		q_job.start_x = start_x_n;
		q_job.start_y = start_y_n;
	end

	// contour state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q   <= 1'b1;
			start_x_q  <= '0;
			start_y_q  <= '0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_vld_q <= 1'b0;
		end else if (accept) begin
			expect_q   <= expect_n;
			start_x_q  <= start_x_n;
			start_y_q  <= start_y_n;
			pend_x_q   <= pend_x_n;
			pend_y_q   <= pend_y_n;
			pend_vld_q <= pend_vld_n;
		end
	end

endmodule

@@ rtl/qcd_fifo.sv @@
// qcd_fifo: short job queue between front and back
module qcd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qcd_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output qcd_pkg::job_t pop_job,
	output logic          empty
);

	qcd_pkg::job_t                entries_q [qcd_pkg::QUEUE_DEPTH];
	logic [qcd_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [qcd_pkg::QCNT_W-1:0]   count_q;

	assign full    = (count_q == qcd_pkg::QCNT_W'(qcd_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/qcd_back.sv @@
// qcd_back: walks each job's slots and issues one command word per cycle unless cmd is stalled
module qcd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  qcd_pkg::job_t    q_job,
	output logic             q_pop,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output qcd_pkg::result_t cmd
);

	qcd_pkg::job_t                cur_q;
	logic [qcd_pkg::SLOTS-1:0]    mask_q;
	logic                         out_vld_q;
	qcd_pkg::result_t             res_q;

	logic [qcd_pkg::SLOTS-1:0]    sel, rest, mask_after;
	logic                         emit;
	qcd_pkg::result_t             res_n;

	// lowest pending slot goes next
	always_comb begin
		sel        = mask_q & (~mask_q + 1'b1);
		rest       = mask_q & ~sel;
		emit       = (mask_q != '0) && (!out_vld_q || cmd_ready);
		mask_after = emit ? rest : mask_q;
		q_pop      = (mask_after == '0) && !q_empty;
	end

	// build the command word for the chosen slot
	always_comb begin
		res_n = '0;
		if (sel[qcd_pkg::SLOT_HEAD]) begin
			res_n.command   = cur_q.head_cmd;
			res_n.ctrl_x    = cur_q.head_cx;
			res_n.ctrl_y    = cur_q.head_cy;
			res_n.end_x     = cur_q.head_ex;
			res_n.end_y     = cur_q.head_ey;
			res_n.bad_start = cur_q.head_bad;
		end else if (sel[qcd_pkg::SLOT_CQUAD]) begin
			res_n.command = qcd_pkg::CMD_QUAD;
			res_n.ctrl_x  = cur_q.pend_x;
			res_n.ctrl_y  = cur_q.pend_y;
			res_n.end_x   = cur_q.start_x;
			res_n.end_y   = cur_q.start_y;
		end else if (sel[qcd_pkg::SLOT_CLINE]) begin
			res_n.command = qcd_pkg::CMD_LINE;
			res_n.end_x   = cur_q.start_x;
			res_n.end_y   = cur_q.start_y;
		end else if (sel[qcd_pkg::SLOT_CLOSE]) begin
			res_n.command = qcd_pkg::CMD_CLOSE;
		end else begin
			res_n.command = qcd_pkg::CMD_FILL;
		end
		res_n.last_of_run = (rest == '0);
	end

	// current job operands
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_n;
		end
	end

	// slot mask and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			mask_q <= q_pop ? q_job.mask : mask_after;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (cmd_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign cmd_valid = out_vld_q;
	assign cmd       = res_q;

endmodule

@@ rtl/quadratic_contour_decomposer.sv @@
// quadratic_contour_decomposer: outline points in, path command words out
//
// Input channel pt (pt_valid/pt_ready) takes one outline point per word with
// its on-curve flag and contour and glyph end marks. Output channel cmd
// (cmd_valid/cmd_ready) gives move, line, quadratic, close and fill words;
// last_of_run marks the final word caused by a point.
// The front classifies each point in the cycle it is taken and writes a job
// into a four-entry queue; the back walks the job, one word per cycle unless
// stalled, into an output register. A point that only becomes a held control
// yields no job. The first word of a point reaches cmd_valid through the
// queue, the back's slot mask and the output register. Throughput: one point
// per cycle while each point yields one word and cmd is not stalled; a
// contour end costs three or four words and a glyph end one more, set by the
// single output word per cycle of the back. When cmd_ready stays low the back
// holds its word, the queue fills and pt_ready falls once four jobs wait.
// Reset clears the queue, the output valid and the contour state; the
// next point then opens a contour.
module quadratic_contour_decomposer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pt_valid,
	output logic             pt_ready,
	input  qcd_pkg::point_t  pt,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output qcd_pkg::result_t cmd
);

	logic          q_full, q_empty, q_push, q_pop;
	qcd_pkg::job_t push_job, pop_job;

	// point classification and contour state
	qcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.pt       (pt),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	// job queue
	qcd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// command sequencer
	qcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

endmodule

@@ rtl/qcd_checker.sv @@
// qcd_checker: port-level assertions for the decomposer, bound to the top level
module qcd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input qcd_pkg::result_t cmd
);

	// a waiting word stays offered
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("cmd_valid dropped before the word was taken");

	// a waiting word keeps its payload
	a_cmd_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> $stable(cmd))
		else $error("cmd payload changed while stalled");

	// fill always ends the run of its point
	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.command == qcd_pkg::CMD_FILL |-> cmd.last_of_run)
		else $error("fill word without last_of_run");

	// only a quadratic carries a control point
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.command != qcd_pkg::CMD_QUAD |->
		cmd.ctrl_x == 16'sd0 && cmd.ctrl_y == 16'sd0)
		else $error("control point on a word that is not a quadratic");

	// bad start is flagged on moves only
	a_bad_move: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.bad_start |-> cmd.command == qcd_pkg::CMD_MOVE)
		else $error("bad_start on a word that is not a move");

endmodule

bind quadratic_contour_decomposer qcd_checker u_qcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd)
);
